// ===== design/chg_pkg.sv =====
// shared types, constants and register codes for the core hotplug governor
package chg_pkg;

   // block sizing
   localparam int TICK_RATE = 100;
   localparam int CORES     = 4;

   // derived widths and values
   localparam int               SEC_CORES      = CORES - 1;
   localparam logic [9:0]       TICK_RATE_IV   = 10'(TICK_RATE);
   localparam logic [9:0]       INTERVAL_RESET = 10'(TICK_RATE / 50);
   localparam logic [7:0]       CTR_MAX        = 8'h7F;
   localparam logic [7:0]       CTR_MIN        = 8'h80;
   localparam int               DOWN_RELOAD    = 2;

   // request function codes
   localparam logic [1:0] FUNC_TICK     = 2'd0;
   localparam logic [1:0] FUNC_DISP_OFF = 2'd1;
   localparam logic [1:0] FUNC_DISP_ON  = 2'd2;

   // result action codes
   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_UP   = 2'd1;
   localparam logic [1:0] ACT_DOWN = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_ENABLE    = 3'd0;
   localparam logic [2:0] CSR_FAST_THR  = 3'd1;
   localparam logic [2:0] CSR_UP_LIM1   = 3'd2;
   localparam logic [2:0] CSR_UP_LIM2   = 3'd3;
   localparam logic [2:0] CSR_UP_LIM3   = 3'd4;
   localparam logic [2:0] CSR_DOWN_LIM1 = 3'd5;
   localparam logic [2:0] CSR_DOWN_LIM2 = 3'd6;
   localparam logic [2:0] CSR_DOWN_LIM3 = 3'd7;

   typedef struct packed {
      logic [1:0]  func;
      logic [3:0]  online_mask;
      logic [3:0]  policy_valid_mask;
      logic [21:0] cur_freq_0;
      logic [21:0] cur_freq_1;
      logic [21:0] cur_freq_2;
      logic [21:0] cur_freq_3;
      logic [21:0] min_freq_0;
      logic [21:0] min_freq_1;
      logic [21:0] min_freq_2;
      logic [21:0] min_freq_3;
   } req_type;

   typedef struct packed {
      logic [1:0] action;
      logic [1:0] target_core;
      logic       boost_to_max;
      logic [9:0] next_interval;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  index;
      logic [21:0] wdata;
   } csr_type;

   typedef struct packed {
      logic            enable;
      logic [21:0]     fast_thr;
      logic [2:0][7:0] up_lim;
      logic [2:0][7:0] down_lim;
   } cfg_type;

   typedef struct packed {
      logic [SEC_CORES-1:0][7:0] counter;
      logic [9:0]                sample_interval;
      logic                      display_on;
   } state_type;

   localparam cfg_type CFG_RESET = '{
      enable:   1'b1,
      fast_thr: 22'd1267200,
      up_lim:   {8'hFE, 8'hFC, 8'hFA},
      down_lim: {8'd14, 8'd9, 8'd5}
   };

endpackage

// ===== design/chg_chan_if.sv =====
// valid/ready channel carrying one payload struct
interface chg_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/chg_policy.sv =====
// per-request decision logic: classifies cores, works counters, picks action
module chg_policy import chg_pkg::*; (
   input  req_type   item_i,
   input  cfg_type   cfg_i,
   input  state_type state_i,
   output state_type state_o,
   output rsp_type   rsp_o
);

   logic [21:0]          cur_freq [4];
   logic [21:0]          min_freq [4];
   logic [CORES-1:0]     online;
   logic [CORES-1:0]     fast;
   logic [CORES-1:0]     low;
   logic                 any_fast;
   logic                 any_low;
   logic                 all_on;
   logic [1:0]           up_core;
   logic                 up_found;
   logic [1:0]           up_idx;
   logic [7:0]           up_ctr;
   logic                 up_fire;
   logic [SEC_CORES-1:0][7:0] dn_ctr;
   logic                 dn_fire;
   logic                 dn_stop;
   logic [1:0]           dn_core;

   // per-core frequency readings
   assign cur_freq[0] = item_i.cur_freq_0;
   assign cur_freq[1] = item_i.cur_freq_1;
   assign cur_freq[2] = item_i.cur_freq_2;
   assign cur_freq[3] = item_i.cur_freq_3;
   assign min_freq[0] = item_i.min_freq_0;
   assign min_freq[1] = item_i.min_freq_1;
   assign min_freq[2] = item_i.min_freq_2;
   assign min_freq[3] = item_i.min_freq_3;

   assign online = item_i.online_mask[CORES-1:0];
   assign all_on = &online;

   // fast and low classification of each core
   always_comb begin
      for (int i = 0; i < CORES; i++) begin
         fast[i] = online[i] && item_i.policy_valid_mask[i] && (cur_freq[i] > cfg_i.fast_thr);
         low[i]  = (i != 0) && online[i] && item_i.policy_valid_mask[i] &&
                   (cur_freq[i] <= cfg_i.fast_thr) && (cur_freq[i] <= min_freq[i]);
      end
   end

   assign any_fast = |fast;
   assign any_low  = |low;

   // highest offline secondary core
   always_comb begin
      up_core  = '0;
      up_found = 1'b0;
      for (int i = 1; i < CORES; i++) begin
         if (!online[i]) begin
            up_core  = 2'(i);
            up_found = 1'b1;
         end
      end
   end

   assign up_idx  = up_core - 2'd1;
   assign up_ctr  = state_i.counter[up_idx];
   assign up_fire = up_found && ($signed(up_ctr) < $signed(cfg_i.up_lim[up_idx]));

   // take-down scan: lowest online secondary first, stops at the first hit
   always_comb begin
      dn_ctr  = state_i.counter;
      dn_fire = 1'b0;
      dn_stop = 1'b0;
      dn_core = '0;
      for (int i = 1; i < CORES; i++) begin
         if (!dn_stop && online[i]) begin
            if ($signed(state_i.counter[i-1]) > $signed(cfg_i.down_lim[i-1])) begin
               dn_ctr[i-1] = cfg_i.down_lim[DOWN_RELOAD];
               dn_fire     = 1'b1;
               dn_core     = 2'(i);
               dn_stop     = 1'b1;
            end else if (state_i.counter[i-1] != CTR_MAX) begin
               dn_ctr[i-1] = state_i.counter[i-1] + 8'd1;
            end
         end
      end
   end

   // next state and result
   always_comb begin
      state_o = state_i;
      rsp_o   = '{action: ACT_NONE, target_core: 2'd0, boost_to_max: 1'b0,
                  next_interval: state_i.sample_interval};
      case (item_i.func)
         FUNC_DISP_OFF: begin
            state_o.display_on = 1'b0;
         end
         FUNC_DISP_ON: begin
            state_o.display_on      = 1'b1;
            state_o.sample_interval = INTERVAL_RESET;
            rsp_o.next_interval     = INTERVAL_RESET;
         end
         FUNC_TICK: begin
            if (cfg_i.enable) begin
               // stretch the interval while the display is off
               if (!state_i.display_on && (state_i.sample_interval < TICK_RATE_IV)) begin
                  state_o.sample_interval = state_i.sample_interval + 10'd1;
               end
               if (any_fast && !all_on) begin
                  if (up_fire) begin
                     state_o.counter[up_idx] = cfg_i.up_lim[0];
                     rsp_o.action            = ACT_UP;
                     rsp_o.target_core       = up_core;
                     rsp_o.boost_to_max      = 1'b1;
                  end else if (up_found && (up_ctr != CTR_MIN)) begin
                     state_o.counter[up_idx] = up_ctr - 8'd1;
                  end
               end else if (any_low) begin
                  state_o.counter = dn_ctr;
                  if (dn_fire) begin
                     rsp_o.action      = ACT_DOWN;
                     rsp_o.target_core = dn_core;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== design/core_hotplug_governor.sv =====
// core hotplug governor top level: input register, decision, result register
// The input register holds each request, the result register its decision.
// Throughput: one request per cycle when unstalled; the result register frees the
// input register whenever it is empty or its result is taken in the same cycle.
// Reset: synchronous; clears counters, restores interval, display on and
// all configuration registers to their defaults, and empties both stages.
module core_hotplug_governor import chg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   chg_chan_if.sink           req_chan,
   chg_chan_if.source         rsp_chan,
   chg_chan_if.sink           csr_chan
);

   logic      s1_valid_ff;
   logic      s1_valid_in;
   req_type   s1_ff;
   logic      out_valid_ff;
   logic      out_valid_in;
   rsp_type   out_ff;
   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type state_ff;
   state_type state_in;
   state_type state_next;
   rsp_type   rsp_next;
   logic      advance;
   logic      req_take;

   // handshake
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_ff;
   assign csr_chan.ready = 1'b1;

   // decision logic
   chg_policy u_policy (
      .item_i  (s1_ff),
      .cfg_i   (cfg_ff),
      .state_i (state_ff),
      .state_o (state_next),
      .rsp_o   (rsp_next)
   );

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.data.index)
            CSR_ENABLE:    cfg_in.enable      = csr_chan.data.wdata[0];
            CSR_FAST_THR:  cfg_in.fast_thr    = csr_chan.data.wdata;
            CSR_UP_LIM1:   cfg_in.up_lim[0]   = csr_chan.data.wdata[7:0];
            CSR_UP_LIM2:   cfg_in.up_lim[1]   = csr_chan.data.wdata[7:0];
            CSR_UP_LIM3:   cfg_in.up_lim[2]   = csr_chan.data.wdata[7:0];
            CSR_DOWN_LIM1: cfg_in.down_lim[0] = csr_chan.data.wdata[7:0];
            CSR_DOWN_LIM2: cfg_in.down_lim[1] = csr_chan.data.wdata[7:0];
            CSR_DOWN_LIM3: cfg_in.down_lim[2] = csr_chan.data.wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // stage valids and governor state
   assign s1_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;
   assign state_in     = (advance && s1_valid_ff) ? state_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff       <= CFG_RESET;
         state_ff     <= '{counter: '0, sample_interval: INTERVAL_RESET, display_on: 1'b1};
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= req_chan.data;
      end
      if (advance && s1_valid_ff) begin
         out_ff <= rsp_next;
      end
   end

   // checks
   a_boost_only_on_up: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.data.boost_to_max == (rsp_chan.data.action == ACT_UP)))
      else $error("boost flag does not match bring-up action");

   a_idle_target_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.data.action == ACT_NONE)) |-> (rsp_chan.data.target_core == 2'd0))
      else $error("target core set without an action");

   a_interval_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.sample_interval <= TICK_RATE_IV)
      else $error("sample interval stretched past tick rate");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_ff) && $stable(state_ff)))
      else $error("stalled request lost or state changed during stall");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the core hotplug governor
`timescale 1ns / 100ps

module testbench import chg_pkg::*; ();

   localparam int         FREQ_MAX    = 4194303;
   localparam int         QUIET_LIMIT = 1000;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef enum {MODE_RAISE, MODE_LOWER, MODE_NOISE} tick_mode_type;

   // tracks governor settings and state, predicts each decision
   class hotplug_ledger_type;
      logic              gov_enable;
      logic [21:0]       fast_thr;
      logic signed [7:0] up_lim [3];
      logic signed [7:0] down_lim [3];
      logic signed [7:0] counter [3];
      logic [9:0]        interval;
      logic              display_on;
      rsp_type           pending_decisions [$];
      int                mismatches;

      function new();
         gov_enable  = 1'b1;
         fast_thr    = 22'd1267200;
         up_lim      = '{-8'sd6, -8'sd4, -8'sd2};
         down_lim    = '{8'sd5, 8'sd9, 8'sd14};
         counter     = '{8'sd0, 8'sd0, 8'sd0};
         interval    = 10'(TICK_RATE / 50);
         display_on  = 1'b1;
         mismatches  = 0;
      endfunction

      function void set_register(input csr_type w);
         case (w.index)
            CSR_ENABLE:    gov_enable  = w.wdata[0];
            CSR_FAST_THR:  fast_thr    = w.wdata;
            CSR_UP_LIM1:   up_lim[0]   = w.wdata[7:0];
            CSR_UP_LIM2:   up_lim[1]   = w.wdata[7:0];
            CSR_UP_LIM3:   up_lim[2]   = w.wdata[7:0];
            CSR_DOWN_LIM1: down_lim[0] = w.wdata[7:0];
            CSR_DOWN_LIM2: down_lim[1] = w.wdata[7:0];
            CSR_DOWN_LIM3: down_lim[2] = w.wdata[7:0];
            default: ;
         endcase
      endfunction

      // work out the decision for one accepted request
      function void note_request(input req_type r);
         rsp_type     d;
         logic [21:0] cur [4];
         logic [21:0] mnf [4];
         int          n_on, n_fast, n_low, k;
         bit          done;
         d = '0;
         n_on = 0;
         n_fast = 0;
         n_low = 0;
         done = 1'b0;
         cur = '{r.cur_freq_0, r.cur_freq_1, r.cur_freq_2, r.cur_freq_3};
         mnf = '{r.min_freq_0, r.min_freq_1, r.min_freq_2, r.min_freq_3};
         d.next_interval = interval;
         if (r.func == FUNC_DISP_OFF) begin
            display_on = 1'b0;
         end else if (r.func == FUNC_DISP_ON) begin
            display_on = 1'b1;
            interval = 10'(TICK_RATE / 50);
            d.next_interval = interval;
         end else if (r.func == FUNC_TICK && gov_enable) begin
            // display off stretches the interval up to the tick rate
            if (!display_on && interval < 10'(TICK_RATE))
               interval = interval + 10'd1;
            for (k = 0; k < CORES; k++) begin
               if (r.online_mask[k]) begin
                  n_on++;
                  if (r.policy_valid_mask[k]) begin
                     if (cur[k] > fast_thr)
                        n_fast++;
                     else if (k != 0 && cur[k] <= mnf[k])
                        n_low++;
                  end
               end
            end
            if (n_fast != 0 && n_on < CORES) begin
               // only the highest offline secondary core is considered
               for (k = CORES - 1; k > 0 && !done; k--) begin
                  if (!r.online_mask[k]) begin
                     done = 1'b1;
                     if (counter[k-1] < up_lim[k-1]) begin
                        counter[k-1]   = up_lim[0];
                        d.action       = ACT_UP;
                        d.target_core  = 2'(k);
                        d.boost_to_max = 1'b1;
                     end else if (counter[k-1] != CTR_MIN) begin
                        counter[k-1] = counter[k-1] - 8'sd1;
                     end
                  end
               end
            end else if (n_low != 0) begin
               // lowest online secondary over its limit goes down
               for (k = 1; k < CORES && !done; k++) begin
                  if (r.online_mask[k]) begin
                     if (counter[k-1] > down_lim[k-1]) begin
                        counter[k-1]  = down_lim[DOWN_RELOAD];
                        d.action      = ACT_DOWN;
                        d.target_core = 2'(k);
                        done          = 1'b1;
                     end else if (counter[k-1] != CTR_MAX) begin
                        counter[k-1] = counter[k-1] + 8'sd1;
                     end
                  end
               end
            end
         end
         pending_decisions.push_back(d);
      endfunction

      // compare one delivered decision against the oldest prediction
      function void check_decision(input rsp_type got);
         rsp_type want;
         if (pending_decisions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected decision: action %0d core %0d boost %0d interval %0d",
                        got.action, got.target_core, got.boost_to_max, got.next_interval);
            return;
         end
         want = pending_decisions.pop_front();
         if (got.action !== want.action || got.target_core !== want.target_core ||
             got.boost_to_max !== want.boost_to_max ||
             got.next_interval !== want.next_interval) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"decision mismatch (exp/got): action %0d/%0d core %0d/%0d ",
                         "boost %0d/%0d interval %0d/%0d"},
                        want.action, got.action, want.target_core, got.target_core,
                        want.boost_to_max, got.boost_to_max,
                        want.next_interval, got.next_interval);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   bit                 bursty;
   int                 quiet;
   hotplug_ledger_type book = new();

   chg_chan_if #(.payload_type(req_type)) req_if ();
   chg_chan_if #(.payload_type(rsp_type)) rsp_if ();
   chg_chan_if #(.payload_type(csr_type)) csr_if ();

   core_hotplug_governor uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // request building
   function automatic req_type pack_req(input logic [1:0] func, input logic [3:0] online,
                                        input logic [3:0] valid, input logic [21:0] cur [4],
                                        input logic [21:0] mnf [4]);
      req_type r;
      r.func              = func;
      r.online_mask       = online;
      r.policy_valid_mask = valid;
      r.cur_freq_0        = cur[0];
      r.cur_freq_1        = cur[1];
      r.cur_freq_2        = cur[2];
      r.cur_freq_3        = cur[3];
      r.min_freq_0        = mnf[0];
      r.min_freq_1        = mnf[1];
      r.min_freq_2        = mnf[2];
      r.min_freq_3        = mnf[3];
      return r;
   endfunction

   function automatic req_type random_req(input logic [1:0] func);
      logic [21:0] cur [4];
      logic [21:0] mnf [4];
      int          k;
      for (k = 0; k < 4; k++) begin
         cur[k] = 22'($urandom);
         mnf[k] = 22'($urandom);
      end
      return pack_req(func, 4'($urandom), 4'($urandom), cur, mnf);
   endfunction

   function automatic req_type shaped_tick(input logic [3:0] online, input logic [3:0] valid,
                                           input logic [21:0] cur_all,
                                           input logic [21:0] min_all);
      logic [21:0] cur [4];
      logic [21:0] mnf [4];
      cur = '{cur_all, cur_all, cur_all, cur_all};
      mnf = '{min_all, min_all, min_all, min_all};
      return pack_req(FUNC_TICK, online, valid, cur, mnf);
   endfunction

   function automatic logic [21:0] fast_freq(input logic [21:0] thr);
      if (thr == 22'(FREQ_MAX))
         return thr;
      return 22'($urandom_range(FREQ_MAX, int'(thr) + 1));
   endfunction

   // tick with random content, shaped toward a bring-up or a take-down, or pure noise
   function automatic req_type make_tick(input tick_mode_type mode, input logic [3:0] online);
      logic [21:0] cur [4];
      logic [21:0] mnf [4];
      logic [3:0]  valid;
      logic [21:0] thr;
      int          k;
      thr = book.fast_thr;
      if (mode == MODE_NOISE)
         return random_req(FUNC_TICK);
      valid = 4'($urandom_range(0, 15));
      for (k = 0; k < 4; k++) begin
         if (mode == MODE_RAISE && $urandom_range(0, 1) == 1)
            cur[k] = fast_freq(thr);
         else
            cur[k] = 22'($urandom_range(int'(thr), 0));
         mnf[k] = 22'($urandom_range(FREQ_MAX, 0));
      end
      if (mode == MODE_RAISE && online != 4'b0000) begin
         do k = $urandom_range(0, 3); while (!online[k]);
         valid[k] = 1'b1;
         cur[k]   = fast_freq(thr);
      end else if (mode == MODE_LOWER && online[3:1] != 3'b000) begin
         do k = $urandom_range(1, 3); while (!online[k]);
         valid[k] = 1'b1;
         mnf[k]   = 22'($urandom_range(FREQ_MAX, int'(cur[k])));
      end
      return pack_req(FUNC_TICK, online, valid, cur, mnf);
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      int      k;
      c.enable   = 1'b1;
      c.fast_thr = 22'($urandom_range(FREQ_MAX, 0));
      for (k = 0; k < SEC_CORES; k++) begin
         c.up_lim[k]   = 8'($urandom_range(4, 0) - 4);
         c.down_lim[k] = 8'($urandom_range(6, 0) - 2);
      end
      return c;
   endfunction

   // drive one request, with an occasional idle burst first
   task automatic send_req(input req_type r);
      if (bursty && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= r;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      book.note_request(r);
   endtask

   // write every register, upper data bits optionally filled with junk
   task automatic program_governor(input cfg_type c, input bit junk);
      csr_type     writes [8];
      logic [21:0] upper;
      int          k;
      upper = junk ? 22'($urandom) : '0;
      writes[0] = '{index: CSR_ENABLE,    wdata: {upper[21:1], c.enable}};
      writes[1] = '{index: CSR_FAST_THR,  wdata: c.fast_thr};
      writes[2] = '{index: CSR_UP_LIM1,   wdata: {upper[21:8], c.up_lim[0]}};
      writes[3] = '{index: CSR_UP_LIM2,   wdata: {upper[21:8], c.up_lim[1]}};
      writes[4] = '{index: CSR_UP_LIM3,   wdata: {upper[21:8], c.up_lim[2]}};
      writes[5] = '{index: CSR_DOWN_LIM1, wdata: {upper[21:8], c.down_lim[0]}};
      writes[6] = '{index: CSR_DOWN_LIM2, wdata: {upper[21:8], c.down_lim[1]}};
      writes[7] = '{index: CSR_DOWN_LIM3, wdata: {upper[21:8], c.down_lim[2]}};
      csr_if.valid <= 1'b1;
      for (k = 0; k < 8; k++) begin
         csr_if.data <= writes[k];
         do @(posedge clock); while (csr_if.ready !== 1'b1);
         book.set_register(writes[k]);
      end
      csr_if.valid <= 1'b0;
   endtask

   // stop requests and wait until every decision is back
   task automatic drain();
      req_if.valid <= 1'b0;
      while (book.pending_decisions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // random traffic: display events, unused function codes and bursts of shaped or noise ticks
   task automatic run_phase(input int count);
      int            sent, pick, burst, k;
      tick_mode_type mode;
      logic [3:0]    online;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_req(random_req(FUNC_DISP_OFF));
            sent++;
         end else if (pick < 12) begin
            send_req(random_req(FUNC_DISP_ON));
            sent++;
         end else if (pick < 15) begin
            send_req(random_req(FUNC_UNUSED));
            sent++;
         end else begin
            pick = $urandom_range(0, 99);
            mode = (pick < 45) ? MODE_RAISE : (pick < 80) ? MODE_LOWER : MODE_NOISE;
            do online = 4'($urandom_range(0, 15));
            while ((mode == MODE_RAISE && (online[3:1] == 3'b111 || online == 4'b0000)) ||
                   (mode == MODE_LOWER && online[3:1] == 3'b000));
            burst = $urandom_range(3, 12);
            for (k = 0; k < burst && sent < count; k++) begin
               send_req(make_tick(mode, online));
               sent++;
            end
         end
      end
   endtask

   // result side with random stall bursts
   initial begin : rsp_side
      int stall;
      stall = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            book.check_decision(rsp_if.data);
         if (stall > 0) begin
            stall--;
            rsp_if.ready <= 1'b0;
         end else if (bursty && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(0, 7);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset) begin
         quiet <= 0;
      end else if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                   (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
                   (csr_if.valid === 1'b1 && csr_if.ready === 1'b1)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // main sequence
   initial begin
      cfg_type plan;
      int      k;
      bursty = 1'b1;
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      csr_if.valid <= 1'b0;
      csr_if.data  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part at reset settings
      send_req(random_req(FUNC_DISP_ON));
      send_req(random_req(FUNC_UNUSED));
      send_req(shaped_tick(4'b0000, 4'b0000, 22'd0, 22'd0));
      // every core online and fast: nothing to raise
      send_req(shaped_tick(4'b1111, 4'b1111, 22'(FREQ_MAX), 22'(FREQ_MAX)));
      // only core 0 offline: no secondary to raise
      send_req(shaped_tick(4'b1110, 4'b1111, 22'(FREQ_MAX), 22'd0));
      // core 3 offline under load: hysteresis then bring-up
      for (k = 0; k < 6; k++)
         send_req(shaped_tick(4'b0111, 4'b0111, 22'(FREQ_MAX), 22'd0));
      // all at minimum: counters climb until core 1 goes down
      for (k = 0; k < 7; k++)
         send_req(shaped_tick(4'b1111, 4'b1111, 22'd0, 22'(FREQ_MAX)));
      // display off stretches the interval, display on restores it
      send_req(random_req(FUNC_DISP_OFF));
      for (k = 0; k < 3; k++)
         send_req(shaped_tick(4'b1011, 4'b1111, 22'd0, 22'd0));
      send_req(random_req(FUNC_DISP_ON));
      // online but no valid readings
      send_req(shaped_tick(4'b0111, 4'b0000, 22'(FREQ_MAX), 22'(FREQ_MAX)));

      run_phase(110);

      drain();
      program_governor(random_settings(), 1'b1);
      run_phase(130);

      // zero threshold, instant bring-up, never down: counters pinned high
      drain();
      plan = '{enable: 1'b1, fast_thr: 22'd0, up_lim: {3{8'h7F}}, down_lim: {3{8'h7F}}};
      program_governor(plan, 1'b0);
      run_phase(70);

      // zero threshold, never up, instant down: counters pinned low
      drain();
      plan = '{enable: 1'b1, fast_thr: 22'd0, up_lim: {3{8'h80}}, down_lim: {3{8'h80}}};
      program_governor(plan, 1'b1);
      run_phase(70);

      // governor off
      drain();
      plan = random_settings();
      plan.enable = 1'b0;
      plan.fast_thr = 22'(FREQ_MAX);
      program_governor(plan, 1'b1);
      run_phase(40);

      // last stretch without idling, highest threshold
      drain();
      bursty = 1'b0;
      plan = random_settings();
      plan.fast_thr = 22'(FREQ_MAX);
      program_governor(plan, 1'b0);
      run_phase(110);

      drain();
      repeat (8) @(posedge clock);
      if (book.mismatches == 0 && book.pending_decisions.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
